// File: sv/bse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bse_pkg
// shared widths, depth and controller-to-datapath command types of the
// bubble sort engine
// ----------------------------------------------------------------------------
package bse_pkg;

   // number of keys the buffer holds (2 .. 64)
   localparam int DEPTH = 64;

   localparam int KEY_W  = 32;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   // source of the buffer write data
   typedef enum logic [1:0] {
      WR_KEY,    // incoming key
      WR_LOW,    // smaller of carry and read data
      WR_CARRY   // carried key at the end of a pass
   } wr_sel_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      wr_sel_type        wr_sel;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              carry_first;
      logic              carry_step;
      logic              out_load;
      logic              out_last;
      logic              out_dropped;
   } bse_cmd_type;

endpackage
`default_nettype wire

// File: sv/bse_channels.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bse channels
// valid/ready interfaces for the key stream and the sorted result stream
// ----------------------------------------------------------------------------
interface bse_req_if;
   import bse_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [KEY_W-1:0] key_value;
   logic                    last_key;

   modport source (output valid, output key_value, output last_key, input ready);
   modport sink (input valid, input key_value, input last_key, output ready);
endinterface

interface bse_rsp_if;
   import bse_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [KEY_W-1:0] sorted_value;
   logic                    last_sorted;
   logic                    keys_dropped;

   modport source (output valid, output sorted_value, output last_sorted,
                   output keys_dropped, input ready);
   modport sink (input valid, input sorted_value, input last_sorted,
                 input keys_dropped, output ready);
endinterface
`default_nettype wire

// File: sv/bubble_sort_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bubble_sort_engine
// collects a set of signed keys, bubble sorts them and streams them out
// ----------------------------------------------------------------------------
// Keys enter one per cycle on req_if while the engine is loading; last_key
// closes the set. Up to DEPTH keys are kept, later keys of the set are
// dropped and every result of that set carries keys_dropped. After the last
// key the engine runs bubble sort passes over the key buffer (one write
// and one read port): one compare-and-swap per cycle, with the larger key
// carried in a register so each position is read once and written once
// per pass. Results then leave lowest first, each by a buffer read and
// then a load of the result register, with last_sorted on the final one;
// the next result is read only once the one before it has been taken.
// Equal keys keep their arrival order. No key is taken while a set is
// sorting or emitting; the next set starts loading once the final result
// transfer completes.
// ----------------------------------------------------------------------------
module bubble_sort_engine (
   input  logic             clock,
   input  logic             reset,
   bse_req_if.sink          req_if,
   bse_rsp_if.source        rsp_if
);
   import bse_pkg::*;

   // command bundle from sequencer to buffer/compare datapath
   bse_cmd_type cmd;

   // sequencer: load count, pass span, compare position, emit index
   bse_controller u_controller (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_if.valid),
      .req_last_key (req_if.last_key),
      .req_ready    (req_if.ready),
      .rsp_valid    (rsp_if.valid),
      .rsp_ready    (rsp_if.ready),
      .cmd          (cmd)
   );

   // key buffer, carried key and the result register that holds a transfer
   bse_datapath u_datapath (
      .clock            (clock),
      .cmd              (cmd),
      .req_key_value    (req_if.key_value),
      .rsp_sorted_value (rsp_if.sorted_value),
      .rsp_last_sorted  (rsp_if.last_sorted),
      .rsp_keys_dropped (rsp_if.keys_dropped)
   );

endmodule
`default_nettype wire

// File: sv/bse_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bse_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module bse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

// File: sv/bse_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bse_datapath
// key buffer, carried key with its compare-and-swap, and the result register
// ----------------------------------------------------------------------------
module bse_datapath (
   input  logic                             clock,
   input  bse_pkg::bse_cmd_type             cmd,
   input  logic signed [bse_pkg::KEY_W-1:0] req_key_value,
   output logic signed [bse_pkg::KEY_W-1:0] rsp_sorted_value,
   output logic                             rsp_last_sorted,
   output logic                             rsp_keys_dropped
);
   import bse_pkg::*;

   logic        [KEY_W-1:0] rd_data;
   logic        [KEY_W-1:0] wr_data;
   logic signed [KEY_W-1:0] rd_key;
   logic signed [KEY_W-1:0] carry_ff;
   logic signed [KEY_W-1:0] carry_in;
   logic                    carry_gt;
   logic signed [KEY_W-1:0] out_value_ff;
   logic                    out_last_ff;
   logic                    out_dropped_ff;

   bse_ram #(
      .WIDTH (KEY_W),
      .DEPTH (DEPTH)
   ) u_key_buffer (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (cmd.wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (cmd.rd_addr),
      .rd_data (rd_data)
   );

   assign rd_key   = $signed(rd_data);
   // swap only when the left key is strictly greater
   assign carry_gt = carry_ff > rd_key;

   always_comb begin
      case (cmd.wr_sel)
         WR_KEY:   wr_data = req_key_value;
         WR_LOW:   wr_data = carry_gt ? rd_data : carry_ff;
         WR_CARRY: wr_data = carry_ff;
         default:  wr_data = carry_ff;
      endcase
   end

   always_comb begin
      carry_in = carry_ff;
      if (cmd.carry_first) begin
         carry_in = rd_key;
      end else if (cmd.carry_step) begin
         carry_in = carry_gt ? carry_ff : rd_key;
      end
   end

   always_ff @(posedge clock) begin
      carry_ff <= carry_in;
      if (cmd.out_load) begin
         out_value_ff   <= rd_key;
         out_last_ff    <= cmd.out_last;
         out_dropped_ff <= cmd.out_dropped;
      end
   end

   assign rsp_sorted_value = out_value_ff;
   assign rsp_last_sorted  = out_last_ff;
   assign rsp_keys_dropped = out_dropped_ff;

endmodule
`default_nettype wire

// File: sv/bse_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bse_controller
// sequencer for key loading, bubble sort passes and result emission
// ----------------------------------------------------------------------------
module bse_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_last_key,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output bse_pkg::bse_cmd_type cmd
);
   import bse_pkg::*;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_PASS_INIT,
      ST_PASS_LOAD,
      ST_PASS_RUN,
      ST_PASS_END,
      ST_EMIT_READ,
      ST_EMIT_LOAD,
      ST_EMIT_WAIT
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              overflow_ff, overflow_in;
   logic [CNT_W-1:0]  span_ff, span_in;
   logic [ADDR_W-1:0] pos_ff, pos_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              req_xfer;
   logic              rsp_xfer;
   logic              buf_full;
   logic [CNT_W-1:0]  count_after;
   logic [CNT_W-1:0]  pos_ahead;
   logic [CNT_W-1:0]  span_less;
   logic [CNT_W-1:0]  idx_next;
   logic              idx_last;

   assign req_ready   = (state_ff == ST_LOAD);
   assign rsp_valid   = rsp_valid_ff;
   assign req_xfer    = req_valid & req_ready;
   assign rsp_xfer    = rsp_valid_ff & rsp_ready;
   assign buf_full    = (count_ff == CNT_W'(DEPTH));
   assign count_after = buf_full ? count_ff : count_ff + CNT_W'(1);
   assign pos_ahead   = CNT_W'(pos_ff) + CNT_W'(2);
   assign span_less   = span_ff - CNT_W'(1);
   assign idx_next    = CNT_W'(idx_ff) + CNT_W'(1);
   assign idx_last    = (idx_next == count_ff);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      overflow_in  = overflow_ff;
      span_in      = span_ff;
      pos_in       = pos_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      cmd.wr_sel   = WR_KEY;

      case (state_ff)
         ST_LOAD: begin
            if (req_xfer) begin
               if (!buf_full) begin
                  cmd.wr_en   = 1'b1;
                  cmd.wr_addr = count_ff[ADDR_W-1:0];
                  cmd.wr_sel  = WR_KEY;
                  count_in    = count_ff + CNT_W'(1);
               end else begin
                  overflow_in = 1'b1;
               end
               if (req_last_key) begin
                  span_in  = count_after;
                  idx_in   = '0;
                  state_in = (count_after >= CNT_W'(2)) ? ST_PASS_INIT : ST_EMIT_READ;
               end
            end
         end
         ST_PASS_INIT: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = '0;
            state_in    = ST_PASS_LOAD;
         end
         ST_PASS_LOAD: begin
            cmd.carry_first = 1'b1;
            cmd.rd_en       = 1'b1;
            cmd.rd_addr     = ADDR_W'(1);
            pos_in          = '0;
            state_in        = ST_PASS_RUN;
         end
         ST_PASS_RUN: begin
            cmd.carry_step = 1'b1;
            cmd.wr_en      = 1'b1;
            cmd.wr_addr    = pos_ff;
            cmd.wr_sel     = WR_LOW;
            if (pos_ahead < span_ff) begin
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = pos_ahead[ADDR_W-1:0];
               pos_in      = pos_ff + ADDR_W'(1);
            end else begin
               state_in = ST_PASS_END;
            end
         end
         ST_PASS_END: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = span_less[ADDR_W-1:0];
            cmd.wr_sel  = WR_CARRY;
            span_in     = span_less;
            if (span_less >= CNT_W'(2)) begin
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = '0;
               state_in    = ST_PASS_LOAD;
            end else begin
               idx_in   = '0;
               state_in = ST_EMIT_READ;
            end
         end
         ST_EMIT_READ: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = idx_ff;
            state_in    = ST_EMIT_LOAD;
         end
         ST_EMIT_LOAD: begin
            cmd.out_load    = 1'b1;
            cmd.out_last    = idx_last;
            cmd.out_dropped = overflow_ff;
            rsp_valid_in    = 1'b1;
            state_in        = ST_EMIT_WAIT;
         end
         ST_EMIT_WAIT: begin
            if (rsp_xfer) begin
               rsp_valid_in = 1'b0;
               if (idx_last) begin
                  count_in    = '0;
                  overflow_in = 1'b0;
                  state_in    = ST_LOAD;
               end else begin
                  idx_in      = idx_next[ADDR_W-1:0];
                  cmd.rd_en   = 1'b1;
                  cmd.rd_addr = idx_next[ADDR_W-1:0];
                  state_in    = ST_EMIT_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      span_ff <= span_in;
      pos_ff  <= pos_in;
      idx_ff  <= idx_in;
   end

`ifndef SYNTHESIS
   a_no_result_while_loading: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |-> !rsp_valid_ff)
      else $error("result valid while keys are loading");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("key count beyond buffer depth");

   a_drop_only_when_full: assert property (@(posedge clock) disable iff (reset)
      overflow_ff |-> buf_full)
      else $error("drop flag set with room left in buffer");

   a_run_inside_span: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PASS_RUN) |-> ((CNT_W'(pos_ff) + CNT_W'(1)) < span_ff))
      else $error("compare position past end of pass");

   a_set_closes: assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && idx_last) |=> (state_ff == ST_LOAD && count_ff == '0 && !overflow_ff))
      else $error("set state not cleared after final result");
`endif

endmodule
`default_nettype wire

// File: tb/bse_sort_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bse_sort_checker
// watches the key and result streams of the bubble sort engine, predicts
// every sorted run and compares it field by field with what leaves the block
// ----------------------------------------------------------------------------
module bse_sort_checker (
   input  logic clock,
   input  logic reset,
   bse_req_if   req_mon,
   bse_rsp_if   rsp_mon,
   output int   mismatch_count,
   output int   results_pending
);
   import bse_pkg::*;

   typedef struct packed {
      logic signed [KEY_W-1:0] value;
      logic                    last;
      logic                    dropped;
   } sorted_entry_type;

   logic signed [KEY_W-1:0] set_keys[$];
   logic                    set_overflow;
   sorted_entry_type        expected_sorted[$];
   int                      error_total;

   // stable ascending sort of the collected set, queued as expected results
   function automatic void queue_sorted_set();
      logic signed [KEY_W-1:0] keys[$];
      logic signed [KEY_W-1:0] held;
      sorted_entry_type        entry;
      int                      n;
      keys = set_keys;
      n = keys.size();
      for (int sweep = 0; sweep + 1 < n; sweep++) begin
         for (int pos = 0; pos + 1 < n - sweep; pos++) begin
            if (keys[pos] > keys[pos + 1]) begin
               held = keys[pos];
               keys[pos] = keys[pos + 1];
               keys[pos + 1] = held;
            end
         end
      end
      for (int k = 0; k < n; k++) begin
         entry.value   = keys[k];
         entry.last    = (k == n - 1);
         entry.dropped = set_overflow;
         expected_sorted.push_back(entry);
      end
      set_keys.delete();
      set_overflow = 1'b0;
   endfunction

   initial begin
      error_total     = 0;
      set_overflow    = 1'b0;
      mismatch_count  = 0;
      results_pending = 0;
   end

   always @(posedge clock) begin
      sorted_entry_type want;
      if (reset) begin
         set_keys.delete();
         expected_sorted.delete();
         set_overflow = 1'b0;
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            if (set_keys.size() < DEPTH)
               set_keys.push_back(req_mon.key_value);
            else
               set_overflow = 1'b1;
            if (req_mon.last_key)
               queue_sorted_set();
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_sorted.size() == 0) begin
               $display("%0t: unexpected result, expected none, got value %0d last %b dropped %b",
                        $time, rsp_mon.sorted_value, rsp_mon.last_sorted,
                        rsp_mon.keys_dropped);
               error_total++;
            end else begin
               want = expected_sorted.pop_front();
               if (rsp_mon.sorted_value !== want.value) begin
                  $display("%0t: sorted_value expected %0d, actual %0d",
                           $time, want.value, rsp_mon.sorted_value);
                  error_total++;
               end
               if (rsp_mon.last_sorted !== want.last) begin
                  $display("%0t: last_sorted expected %b, actual %b",
                           $time, want.last, rsp_mon.last_sorted);
                  error_total++;
               end
               if (rsp_mon.keys_dropped !== want.dropped) begin
                  $display("%0t: keys_dropped expected %b, actual %b",
                           $time, want.dropped, rsp_mon.keys_dropped);
                  error_total++;
               end
            end
         end
      end
      mismatch_count  <= error_total;
      results_pending <= expected_sorted.size();
   end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the bubble sort engine
// ----------------------------------------------------------------------------
// Short directed sets first (single keys, extremes, equal keys, sorted and
// reverse sorted input), then random sets of random size through four
// idling phases, the second led by an overflowing set whose last key is
// dropped, the third by a full buffer. bse_sort_checker predicts and checks.
// ----------------------------------------------------------------------------
module tb;
   import bse_pkg::*;

   localparam int SILENCE_LIMIT   = 12000;  // longest wait with no transfer before the watchdog fires
   localparam int DRAIN_CYCLES    = 40;
   localparam int ITEMS_PER_PHASE = 55;

   localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W - 1){1'b0}}};
   localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W - 1){1'b1}}};

   logic clock;
   logic reset;

   int send_idle_pct;     // chance in a hundred that the key source holds off
   int stall_pct;         // chance in a hundred that the result sink stalls
   int phase_items;       // keys sent in the current idling phase
   int silent_cycles = 0; // cycles since the last transfer on either stream
   int mismatch_count;
   int results_pending;

   logic signed [KEY_W-1:0] batch[$];

   bse_req_if req_chan();
   bse_rsp_if rsp_chan();

   bubble_sort_engine uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_chan),
      .rsp_if (rsp_chan)
   );

   bse_sort_checker sort_check (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_chan),
      .rsp_mon         (rsp_chan),
      .mismatch_count  (mismatch_count),
      .results_pending (results_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // key mix: extremes, tiny range for duplicates, otherwise full 32 bits
   function automatic logic signed [KEY_W-1:0] draw_key();
      case ($urandom_range(9))
         0: return KEY_MIN;
         1: return KEY_MAX;
         2: return '0;
         3: return -1;
         4, 5: return $signed($urandom_range(7)) - 4;
         default: return $urandom();
      endcase
   endfunction

   // mostly short sets so sorting stays cheap, now and then a longer one
   function automatic int pick_set_size();
      case ($urandom_range(11))
         0: return 1;
         1: return $urandom_range(16, 40);
         default: return $urandom_range(2, 12);
      endcase
   endfunction

   // one key transfer, with random hold-off before raising valid
   task automatic send_key(input logic signed [KEY_W-1:0] key, input logic is_last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.key_value <= key;
      req_chan.last_key  <= is_last;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      phase_items++;
   endtask

   // directed set held in batch, last mark on its final key
   task automatic send_batch();
      foreach (batch[i])
         send_key(batch[i], i == batch.size() - 1);
   endtask

   task automatic send_random_set(input int count);
      for (int i = 0; i < count; i++)
         send_key(draw_key(), i == count - 1);
   endtask

   // result sink: ready redrawn every cycle
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // watchdog: cycles with no transfer on either stream
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         silent_cycles <= 0;
      else
         silent_cycles <= silent_cycles + 1;
   end

   initial begin
      while (silent_cycles < SILENCE_LIMIT)
         @(posedge clock);
      $display("%0t: watchdog, no transfer for %0d cycles", $time, SILENCE_LIMIT);
      $display("Mismatches found");
      $finish;
   end

   initial begin
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.key_value = '0;
      req_chan.last_key  = 1'b0;
      send_idle_pct      = 0;
      stall_pct          = 0;
      phase_items        = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed sets, no idling
      batch = '{KEY_MIN};
      send_batch();
      batch = '{KEY_MAX};
      send_batch();
      batch = '{KEY_MAX, KEY_MIN};
      send_batch();
      batch = '{0, -1, 1, KEY_MIN, KEY_MAX, -1};
      send_batch();
      // equal keys; their arrival order is kept, though equal values cannot show it
      batch = '{5, 5, 5};
      send_batch();
      batch = '{-3, -2, -1, 0};
      send_batch();
      batch = '{3, 2, 1, 0, -1, -2};
      send_batch();

      // random phases: none, source idle, sink stalls, both
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 65; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 65; end
            default: begin send_idle_pct = 38; stall_pct = 38; end
         endcase
         // overflow, including a dropped key that carries the last mark
         if (phase == 1)
            send_random_set(DEPTH + 2);
         // buffer filled exactly, nothing dropped
         if (phase == 2)
            send_random_set(DEPTH);
         phase_items = 0;
         while (phase_items < ITEMS_PER_PHASE)
            send_random_set(pick_set_size());
      end
      req_chan.valid <= 1'b0;

      // checker outputs are registered, so wait before reading them
      @(posedge clock);
      while (results_pending != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && results_pending == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
